FILE: src/fbfs_pkg.sv
// Shared types and constants for the frame store fill and scroll engine.
package fbfs_pkg;

  // Internal byte address width: covers y * pitch + x * 4 for all register values.
  localparam int ADDR_W = 29;

  // Command codes.
  localparam logic [2:0] CMD_PLOT   = 3'd0;
  localparam logic [2:0] CMD_FILL   = 3'd1;
  localparam logic [2:0] CMD_SCROLL = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_PITCH  = 3'd2;
  localparam logic [2:0] CFG_BPP    = 3'd3;
  localparam logic [2:0] CFG_READY  = 3'd4;

  // Request from the sequencer to the frame store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: src/fbfs_store.sv
// Byte-wide frame store with one write and one registered read port.
module fbfs_store #(
  parameter int STORE_BYTES = 262144
) (
  input  logic              clk,
  input  fbfs_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);
  import fbfs_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] mem_q;
  logic       rd_out;

  // Writes beyond the store are dropped.
  always_ff @(posedge clk) begin
    if (req.we && (req.waddr < ADDR_W'(STORE_BYTES))) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  // Registered read; a byte beyond the store reads as zero.
  always_ff @(posedge clk) begin
    mem_q  <= mem[req.raddr[AW-1:0]];
    rd_out <= (req.raddr >= ADDR_W'(STORE_BYTES));
  end

  assign rd_data = rd_out ? 8'h00 : mem_q;

endmodule

FILE: src/framebuffer_fill_scroll_engine_top.sv
// Top level of the frame store fill and scroll engine: command sequencer and registers.
// A plot writes the bytes of its pixel, a read pixel reads its bytes one at a time, a fill
// walks the clipped rectangle row by row, and a scroll moves the kept bytes and then fills
// the vacated lines; invalid and no-op commands go straight to the answer; one command is in work at a time.
// Reset returns the registers to their defaults and runs a clearing pass over all STORE_BYTES bytes
// that zeroes the store; no command is taken until it ends, configuration writes are taken.
module framebuffer_fill_scroll_engine_top #(
  parameter int STORE_BYTES = 262144
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [2:0]  command,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] rect_w,
  input  logic signed [15:0] rect_h,
  input  logic signed [15:0] scroll_lines,
  input  logic        [31:0] pixel_color,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic        [31:0] read_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);
  import fbfs_pkg::*;

  localparam int CNT_W = $clog2(STORE_BYTES) + 1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CLIP, S_MULT, S_ROW, S_FILL, S_RD_REQ, S_RD_WAIT,
    S_SCR_SET1, S_SCR_SET2, S_SCR_RD, S_SCR_WR, S_RESP
  } state_t;

  state_t state;

  // Configuration registers.
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic [14:0] line_pitch;
  logic [5:0]  bits_per_pixel;
  logic        engine_ready;

  // Command registers.
  logic signed [17:0] rx, ry, rw, rh;
  logic        [31:0] color;
  logic signed [15:0] lines;
  logic               rd_mode;
  logic               st_r;
  logic        [31:0] data_r;

  // Walk registers.
  logic [12:0]       cx, cy, cw, ch;
  logic              clip_empty;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] addr;
  logic [12:0]       px_left;
  logic [12:0]       rows_left;
  logic [1:0]        k;
  logic [12:0]       mv;
  logic [27:0]       prod;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  cnt;
  logic [ADDR_W-1:0] src;

  mem_req_t   req;
  logic [7:0] q;
  logic [2:0] nb;
  logic       brk;
  logic [7:0] color_byte;

  logic signed [17:0] fw_s, fh_s, sl_s;
  logic signed [17:0] px_s, py_s, pw_s, ph_s;
  logic signed [17:0] cx1, cw1, cy1, ch1;

  assign fw_s = $signed({5'b0, frame_width});
  assign fh_s = $signed({5'b0, frame_height});
  assign sl_s = $signed({{2{scroll_lines[15]}}, scroll_lines});
  assign px_s = $signed({{2{pos_x[15]}}, pos_x});
  assign py_s = $signed({{2{pos_y[15]}}, pos_y});
  assign pw_s = $signed({{2{rect_w[15]}}, rect_w});
  assign ph_s = $signed({{2{rect_h[15]}}, rect_h});

  // Bytes per pixel; zero for depths that do not draw.
  always_comb begin
    priority if (bits_per_pixel == 6'd32) nb = 3'd4;
    else if (bits_per_pixel == 6'd24) nb = 3'd3;
    else nb = 3'd0;
  end

  // Clip the rectangle against the screen edges.
  always_comb begin
    cx1 = rx[17] ? 18'sd0 : rx;
    cw1 = rx[17] ? (rw + rx) : rw;
    if ((cx1 + cw1) > fw_s) cw1 = fw_s - cx1;
    cy1 = ry[17] ? 18'sd0 : ry;
    ch1 = ry[17] ? (rh + ry) : rh;
    if ((cy1 + ch1) > fh_s) ch1 = fh_s - cy1;
  end

  // A pixel that starts beyond the store ends its row.
  assign brk = (k == 2'd0) && (addr >= ADDR_W'(STORE_BYTES));

  always_comb begin
    unique case (k)
      2'd0:    color_byte = color[7:0];
      2'd1:    color_byte = color[15:8];
      2'd2:    color_byte = color[23:16];
      default: color_byte = color[31:24];
    endcase
  end

  // Frame store access by state.
  always_comb begin
    req = '0;
    unique case (state)
      S_CLR: begin
        req.we    = 1'b1;
        req.waddr = addr;
        req.wdata = 8'h00;
      end
      S_FILL: begin
        req.we    = !brk;
        req.waddr = addr;
        req.wdata = color_byte;
      end
      S_RD_REQ: req.raddr = row_base + ADDR_W'(k);
      S_SCR_RD: req.raddr = src;
      S_SCR_WR: begin
        req.we    = 1'b1;
        req.waddr = ADDR_W'(cnt);
        req.wdata = q;
      end
      default: req = '0;
    endcase
  end

  fbfs_store #(.STORE_BYTES(STORE_BYTES)) u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (q)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      addr           <= '0;
      out_valid      <= 1'b0;
      frame_width    <= 13'd256;
      frame_height   <= 13'd256;
      line_pitch     <= 15'd1024;
      bits_per_pixel <= 6'd32;
      engine_ready   <= 1'b0;
    end else begin
      // A result transfer empties the output register unless a new result loads it.
      if (out_valid && out_ready && (state != S_RESP)) out_valid <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WIDTH:  frame_width    <= cfg_data[12:0];
          CFG_HEIGHT: frame_height   <= cfg_data[12:0];
          CFG_PITCH:  line_pitch     <= cfg_data[14:0];
          CFG_BPP:    bits_per_pixel <= cfg_data[5:0];
          CFG_READY:  engine_ready   <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_CLR: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_W'(STORE_BYTES - 1)) state <= S_IDLE;
        end

        S_IDLE: begin
          if (in_valid) begin
            data_r <= '0;
            color  <= pixel_color;
            lines  <= scroll_lines;
            unique case (command)
              CMD_PLOT: begin
                st_r    <= 1'b0;
                rd_mode <= 1'b0;
                rx      <= px_s;
                ry      <= py_s;
                rw      <= 18'sd1;
                rh      <= 18'sd1;
                state   <= (engine_ready && nb != 3'd0) ? S_CLIP : S_RESP;
              end
              CMD_FILL: begin
                st_r    <= 1'b0;
                rd_mode <= 1'b0;
                rx      <= px_s;
                ry      <= py_s;
                rw      <= pw_s;
                rh      <= ph_s;
                state   <= (engine_ready && nb != 3'd0) ? S_CLIP : S_RESP;
              end
              CMD_CLEAR: begin
                st_r    <= 1'b0;
                rd_mode <= 1'b0;
                rx      <= 18'sd0;
                ry      <= 18'sd0;
                rw      <= fw_s;
                rh      <= fh_s;
                state   <= (engine_ready && nb != 3'd0) ? S_CLIP : S_RESP;
              end
              CMD_READ: begin
                st_r    <= 1'b0;
                rd_mode <= 1'b1;
                rx      <= px_s;
                ry      <= py_s;
                rw      <= 18'sd1;
                rh      <= 18'sd1;
                state   <= (nb != 3'd0) ? S_CLIP : S_RESP;
              end
              CMD_SCROLL: begin
                st_r    <= 1'b0;
                rd_mode <= 1'b0;
                rx      <= 18'sd0;
                ry      <= 18'sd0;
                rw      <= fw_s;
                rh      <= fh_s;
                if (!engine_ready || sl_s <= 18'sd0) begin
                  state <= S_RESP;
                end else if (sl_s >= fh_s) begin
                  state <= (nb != 3'd0) ? S_CLIP : S_RESP;
                end else begin
                  mv    <= frame_height - scroll_lines[12:0];
                  state <= S_SCR_SET1;
                end
              end
              default: begin
                st_r    <= 1'b1;
                rd_mode <= 1'b0;
                state   <= S_RESP;
              end
            endcase
          end
        end

        S_CLIP: begin
          cx         <= cx1[12:0];
          cy         <= cy1[12:0];
          cw         <= cw1[12:0];
          ch         <= ch1[12:0];
          clip_empty <= (cw1 <= 18'sd0) || (ch1 <= 18'sd0);
          state      <= S_MULT;
        end

        S_MULT: begin
          k         <= 2'd0;
          row_base  <= ADDR_W'(cy * line_pitch) + ADDR_W'(cx * nb);
          rows_left <= ch;
          if (clip_empty) state <= S_RESP;
          else state <= rd_mode ? S_RD_REQ : S_ROW;
        end

        S_ROW: begin
          if (row_base >= ADDR_W'(STORE_BYTES)) begin
            state <= S_RESP;
          end else begin
            addr    <= row_base;
            px_left <= cw;
            k       <= 2'd0;
            state   <= S_FILL;
          end
        end

        S_FILL: begin
          // End of row: the last byte of the last pixel, or a pixel beyond the store.
          if (brk || ((k == nb[1:0] - 2'd1) && px_left == 13'd1)) begin
            k <= 2'd0;
            if (rows_left == 13'd1 || line_pitch == 15'd0) begin
              state <= S_RESP;
            end else begin
              rows_left <= rows_left - 1'b1;
              row_base  <= row_base + ADDR_W'(line_pitch);
              state     <= S_ROW;
            end
          end else begin
            addr <= addr + 1'b1;
            if (k == nb[1:0] - 2'd1) begin
              k       <= 2'd0;
              px_left <= px_left - 1'b1;
            end else begin
              k <= k + 1'b1;
            end
          end
        end

        S_RD_REQ: state <= S_RD_WAIT;

        S_RD_WAIT: begin
          data_r[8*k +: 8] <= q;
          if (k == nb[1:0] - 2'd1) begin
            state <= S_RESP;
          end else begin
            k     <= k + 1'b1;
            state <= S_RD_REQ;
          end
        end

        S_SCR_SET1: begin
          prod  <= mv * line_pitch;
          state <= S_SCR_SET2;
        end

        S_SCR_SET2: begin
          n     <= (prod > 28'(STORE_BYTES)) ? CNT_W'(STORE_BYTES) : CNT_W'(prod);
          src   <= ADDR_W'(lines[12:0] * line_pitch);
          cnt   <= '0;
          state <= S_SCR_RD;
        end

        S_SCR_RD: begin
          if (cnt == n) begin
            // Row move done; fill the vacated bottom lines.
            rx    <= 18'sd0;
            ry    <= $signed({5'b0, mv});
            rw    <= fw_s;
            rh    <= $signed({{2{lines[15]}}, lines});
            state <= (nb != 3'd0) ? S_CLIP : S_RESP;
          end else begin
            state <= S_SCR_WR;
          end
        end

        S_SCR_WR: begin
          cnt   <= cnt + 1'b1;
          src   <= src + 1'b1;
          state <= S_SCR_RD;
        end

        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= st_r;
            read_data <= data_r;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A row move never writes at or beyond its byte count.
  a_scr_dst: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCR_WR) |-> (cnt < n))
    else $error("scroll copy wrote past its byte count");

  // Drawing only runs at a depth that draws.
  a_fill_nb: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (nb != 3'd0))
    else $error("fill walk at a non-drawing depth");

  // An invalid command always answers zero data.
  a_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (read_data == 32'd0))
    else $error("invalid command returned data");

  // One command at a time: a transfer makes the input busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a command was in work");

endmodule

FILE: dv/framebuffer_fill_scroll_engine_top_tb.sv
// Self-checking testbench for the frame store fill and scroll engine: random commands checked against a byte-level frame model.
module framebuffer_fill_scroll_engine_top_tb;
  import fbfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE = 262144;
  localparam logic [2:0] CMD_FIRST_INVALID = 3'd5;
  localparam logic [2:0] CMD_LAST_INVALID  = 3'd7;

  typedef struct {
    logic        [2:0]  cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic signed [15:0] lines;
    logic        [31:0] color;
  } draw_cmd_t;

  typedef struct {
    logic        status;
    logic [31:0] data;
  } answer_t;

  // Frame model: mirrors the store and registers, and queues the answers it expects.
  class frame_scoreboard;
    logic [7:0]  store [STORE];
    int unsigned width, height, pitch, bpp;
    bit          ready;
    answer_t     pending [$];
    int          errors;

    function void clear_all();
      foreach (store[i]) store[i] = '0;
      width = 256; height = 256; pitch = 1024; bpp = 32; ready = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_WIDTH:  width  = 32'(val[12:0]);
        CFG_HEIGHT: height = 32'(val[12:0]);
        CFG_PITCH:  pitch  = 32'(val[14:0]);
        CFG_BPP:    bpp    = 32'(val[5:0]);
        CFG_READY:  ready  = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pixel_size();
      if (bpp == 32) return 4;
      if (bpp == 24) return 3;
      return 0;
    endfunction

    function void put_pixel(longint unsigned a, int unsigned nb, logic [31:0] color);
      for (int k = 0; k < nb; k++)
        if (a + k < STORE) store[a + k] = color[8*k +: 8];
    endfunction

    function logic [7:0] byte_at(longint unsigned a);
      return (a < STORE) ? store[a] : 8'h00;
    endfunction

    function void fill_rect(longint x, longint y, longint w, longint h, logic [31:0] color);
      int unsigned nb;
      longint unsigned base;
      nb = pixel_size();
      if (!ready || nb == 0) return;
      if (x < 0) begin w += x; x = 0; end
      if (y < 0) begin h += y; y = 0; end
      if (x + w > longint'(width)) w = longint'(width) - x;
      if (y + h > longint'(height)) h = longint'(height) - y;
      if (w <= 0 || h <= 0) return;
      for (longint row = y; row < y + h; row++) begin
        base = row * pitch + x * nb;
        if (base >= STORE) break;
        for (longint i = 0; i < w; i++) begin
          if (base + i * nb >= STORE) break;
          put_pixel(base + i * nb, nb, color);
        end
        if (pitch == 0) break;
      end
    endfunction

    function void scroll_up(longint lines, logic [31:0] color);
      longint unsigned moved, n, src;
      if (!ready || lines <= 0) return;
      if (lines >= longint'(height)) begin
        fill_rect(0, 0, longint'(width), longint'(height), color);
        return;
      end
      moved = height - lines;
      n = moved * pitch;
      src = lines * pitch;
      if (n > STORE) n = STORE;
      for (longint unsigned i = 0; i < n; i++) store[i] = byte_at(src + i);
      fill_rect(0, moved, longint'(width), lines, color);
    endfunction

    function logic [31:0] pixel_at(longint x, longint y);
      int unsigned nb;
      logic [31:0] v;
      longint unsigned a;
      nb = pixel_size();
      v = '0;
      if (nb == 0) return '0;
      if (x < 0 || y < 0 || x >= longint'(width) || y >= longint'(height)) return '0;
      a = y * pitch + x * nb;
      for (int k = 0; k < nb; k++) v[8*k +: 8] = byte_at(a + k);
      return v;
    endfunction

    // Applies an accepted command to the model and queues its answer.
    function void note_command(draw_cmd_t c);
      answer_t ans;
      ans.status = 1'b0;
      ans.data = '0;
      case (c.cmd)
        CMD_PLOT: begin
          if (ready && pixel_size() != 0 && c.x >= 0 && c.y >= 0 &&
              c.x < longint'(width) && c.y < longint'(height))
            put_pixel(longint'(c.y) * pitch + longint'(c.x) * pixel_size(), pixel_size(),
                      c.color);
        end
        CMD_FILL:   fill_rect(longint'(c.x), longint'(c.y), longint'(c.w), longint'(c.h),
                              c.color);
        CMD_SCROLL: scroll_up(longint'(c.lines), c.color);
        CMD_CLEAR:  fill_rect(0, 0, longint'(width), longint'(height), c.color);
        CMD_READ:   ans.data = pixel_at(longint'(c.x), longint'(c.y));
        default:    ans.status = 1'b1;
      endcase
      pending.push_back(ans);
    endfunction

    // Compares one result transfer with the oldest expected answer.
    function void check_result(logic status, logic [31:0] data);
      answer_t ans;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d read_data %08h", status, data);
        errors++;
        return;
      end
      ans = pending.pop_front();
      if (status !== ans.status) begin
        $error("status: expected %0d, actual %0d", ans.status, status);
        errors++;
      end
      if (data !== ans.data) begin
        $error("read_data: expected %08h, actual %08h", ans.data, data);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [2:0]  command = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [15:0] rect_w = '0;
  logic signed [15:0] rect_h = '0;
  logic signed [15:0] scroll_lines = '0;
  logic        [31:0] pixel_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               status;
  logic        [31:0] read_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [2:0]  cfg_index = '0;
  logic        [31:0] cfg_data = '0;

  frame_scoreboard frames;
  bit  calm;
  bit  hold_off_req;
  bit  big_screen;

  framebuffer_fill_scroll_engine_top DUT (.*);

  always #5 clk = ~clk;

  // Run limit.
  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int draw_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      frames.check_result(status, read_data);
      @(negedge clk);
    end
  end

  // Sends one command; called and returns at a falling edge.
  task automatic send_command(draw_cmd_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command      <= c.cmd;
    pos_x        <= c.x;
    pos_y        <= c.y;
    rect_w       <= c.w;
    rect_h       <= c.h;
    scroll_lines <= c.lines;
    pixel_color  <= c.color;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    frames.note_command(c);
    @(negedge clk);
  endtask

  task automatic send_fields(logic [2:0] cmd, int x, int y, int w, int h, int lines,
                             logic [31:0] color);
    draw_cmd_t c;
    c.cmd = cmd; c.x = 16'(x); c.y = 16'(y); c.w = 16'(w); c.h = 16'(h);
    c.lines = 16'(lines); c.color = color;
    send_command(c);
  endtask

  // Waits until every answer has come back, with the input channel quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frames.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    frames.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_screen(int w, int h, int p, int b, bit rdy);
    wait_idle();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_PITCH, p);
    write_reg(CFG_BPP, b);
    write_reg(CFG_READY, 32'(rdy));
    big_screen = (w * h > 4096);
  endtask

  function automatic int near_range(int lim);
    if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom())));
    return $urandom_range(0, lim + 8) - 4;
  endfunction

  // Random command; on large screens with drawing enabled fills stay tiny and scroll and clear are left out.
  function automatic draw_cmd_t random_command();
    draw_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.color = $urandom();
    c.lines = 16'(near_range(frames.height));
    if (pick < 25)      c.cmd = CMD_PLOT;
    else if (pick < 45) c.cmd = CMD_FILL;
    else if (pick < 55) c.cmd = CMD_SCROLL;
    else if (pick < 60) c.cmd = CMD_CLEAR;
    else if (pick < 90) c.cmd = CMD_READ;
    else c.cmd = 3'($urandom_range(CMD_FIRST_INVALID, CMD_LAST_INVALID));
    if (big_screen && frames.ready) begin
      if (c.cmd == CMD_SCROLL || c.cmd == CMD_CLEAR) c.cmd = CMD_READ;
      c.x = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, frames.width));
      c.y = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, frames.height));
      c.w = 16'($urandom_range(0, 10) - 2);
      c.h = 16'($urandom_range(0, 10) - 2);
    end else begin
      c.x = 16'(near_range(frames.width));
      c.y = 16'(near_range(frames.height));
      c.w = 16'(near_range(frames.width));
      c.h = 16'(near_range(frames.height));
    end
    return c;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_command(random_command());
    end
  endtask

  // Stimulus sequence.
  initial begin
    frames = new();
    frames.clear_all();
    calm = 0;
    hold_off_req = 0;
    big_screen = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Engine not ready: drawing is a no-op, reads and invalid codes still answer.
    send_fields(CMD_SCROLL, 0, 0, 0, 0, 32767, 32'hFFFF_FFFF);
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_fields(CMD_PLOT, 3, 3, 0, 0, 0, 32'hDEAD_BEEF);
    send_fields(CMD_READ, 3, 3, 0, 0, 0, 0);
    send_fields(CMD_FIRST_INVALID, 0, 0, 0, 0, 0, 0);
    send_fields(3'd6, -1, -1, -1, -1, -1, 32'hFFFF_FFFF);
    send_fields(CMD_LAST_INVALID, 0, 0, 0, 0, 0, 0);

    // Small screen, drawing enabled: edges, clipping and scroll cases.
    set_screen(16, 12, 80, 32, 1);
    send_fields(CMD_PLOT, 0, 0, 0, 0, 0, 32'h1122_3344);
    send_fields(CMD_PLOT, 15, 11, 0, 0, 0, 32'hA5A5_5A5A);
    send_fields(CMD_PLOT, 16, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_fields(CMD_PLOT, -32768, 32767, 0, 0, 0, 32'hFFFF_FFFF);
    send_fields(CMD_FILL, -3, -2, 8, 6, 0, 32'h0F0F_0F0F);
    send_fields(CMD_FILL, 10, 8, 32767, 32767, 0, 32'hF0F0_F0F0);
    send_fields(CMD_FILL, 4, 4, 0, -32768, 0, 32'hFFFF_FFFF);
    send_fields(CMD_READ, 0, 0, 0, 0, 0, 0);
    send_fields(CMD_READ, 15, 11, 0, 0, 0, 0);
    send_fields(CMD_READ, -1, 0, 0, 0, 0, 0);
    send_fields(CMD_SCROLL, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_fields(CMD_SCROLL, 0, 0, 0, 0, -32768, 32'hFFFF_FFFF);
    send_fields(CMD_SCROLL, 0, 0, 0, 0, 3, 32'h0000_00FF);
    send_fields(CMD_READ, 15, 8, 0, 0, 0, 0);
    send_fields(CMD_SCROLL, 0, 0, 0, 0, 12, 32'h7777_7777);
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 0, 32'h0000_0000);

    // Random part: long receiver hold-off early, then a full drain.
    hold_off_req = 1;
    random_phase(60);
    wait_idle();
    random_phase(90);

    set_screen(20, 10, 64, 24, 1);
    random_phase(130);
    set_screen(1, 1, 4, 32, 1);
    random_phase(50);
    set_screen(0, 0, 0, 32, 1);
    random_phase(40);
    set_screen(13, 9, 0, 32, 1);
    random_phase(60);
    set_screen(10, 8, 40, 8, 1);
    random_phase(60);
    set_screen(10, 8, 40, 0, 1);
    random_phase(40);
    set_screen(24, 16, 72, 24, 1);
    random_phase(130);
    set_screen(4096, 4096, 16384, 32, 1);
    random_phase(110);
    set_screen(4096, 4096, 16384, 32, 0);
    random_phase(40);
    set_screen(4096, 64, 16384, 24, 1);
    random_phase(50);
    set_screen(16, 12, 80, 32, 1);
    random_phase(170);

    wait_idle();
    repeat (100) @(negedge clk);
    if (frames.errors == 0 && frames.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
